// ----- rtl/csvp_pkg.sv -----
`default_nettype none
package csvp_pkg;

  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  localparam logic [CHAR_W-1:0] DELIMITER_RESET = 8'd44;
  localparam logic [CHAR_W-1:0] QUOTE_RESET     = 8'd34;

  typedef enum logic [0:0] {
    REG_DELIMITER = 1'b0,
    REG_QUOTE     = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_QUOTED     = 2'd1,
    MODE_QUOTE_SEEN = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] delimiter_char;
    logic [CHAR_W-1:0] quote_char;
  } cfg_t;

  typedef struct packed {
    mode_t parse_mode;
    logic  field_has_chars;
    logic  row_has_bytes;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    parse_mode:      MODE_NORMAL,
    field_has_chars: 1'b0,
    row_has_bytes:   1'b0
  };

  typedef struct packed {
    logic [CHAR_W-1:0] out_byte;
    logic              byte_valid;
    logic              field_end;
    logic              row_end;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/csvp_cfg.sv -----
`default_nettype none
module csvp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire csvp_pkg::reg_index_t        cfg_index,
  input  wire logic [csvp_pkg::CHAR_W-1:0] cfg_data,
  output csvp_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= csvp_pkg::DELIMITER_RESET;
      cfg.quote_char     <= csvp_pkg::QUOTE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        csvp_pkg::REG_DELIMITER: cfg.delimiter_char <= cfg_data;
        csvp_pkg::REG_QUOTE:     cfg.quote_char     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csvp_decode.sv -----
`default_nettype none
module csvp_decode (
  input  wire csvp_pkg::cfg_t              cfg,
  input  wire csvp_pkg::parse_state_t      state,
  input  wire logic [csvp_pkg::CHAR_W-1:0] data_byte,
  input  wire logic                        end_of_input,
  output csvp_pkg::parse_state_t           state_next,
  output logic                             emit,
  output csvp_pkg::result_t                result
);

  logic is_quote;
  logic is_delim;
  logic is_lf;
  logic is_cr;

  assign is_quote = (data_byte == cfg.quote_char);
  assign is_delim = (data_byte == cfg.delimiter_char);
  assign is_lf    = (data_byte == csvp_pkg::CH_LF);
  assign is_cr    = (data_byte == csvp_pkg::CH_CR);

  // next state
  always_comb begin
    state_next = state;
    if (end_of_input) begin
      state_next = csvp_pkg::STATE_RESET;
    end else begin
      state_next.row_has_bytes = 1'b1;
      case (state.parse_mode)
        csvp_pkg::MODE_QUOTED: begin
          if (is_quote) begin
            state_next.parse_mode = csvp_pkg::MODE_QUOTE_SEEN;
          end else begin
            state_next.field_has_chars = 1'b1;
          end
        end
        csvp_pkg::MODE_QUOTE_SEEN: begin
          if (is_quote) begin
            state_next.parse_mode      = csvp_pkg::MODE_QUOTED;
            state_next.field_has_chars = 1'b1;
          end else if (is_delim) begin
            state_next.parse_mode      = csvp_pkg::MODE_NORMAL;
            state_next.field_has_chars = 1'b0;
          end else if (is_lf) begin
            state_next = csvp_pkg::STATE_RESET;
          end else if (is_cr) begin
            state_next.parse_mode = csvp_pkg::MODE_QUOTE_SEEN;
          end else begin
            // stray byte after a closing quote stays in the field
            state_next.parse_mode      = csvp_pkg::MODE_NORMAL;
            state_next.field_has_chars = 1'b1;
          end
        end
        default: begin
          state_next.parse_mode = csvp_pkg::MODE_NORMAL;
          if (is_quote && !state.field_has_chars) begin
            state_next.parse_mode = csvp_pkg::MODE_QUOTED;
          end else if (is_delim) begin
            state_next.field_has_chars = 1'b0;
          end else if (is_lf) begin
            state_next = csvp_pkg::STATE_RESET;
          end else if (!is_cr) begin
            state_next.field_has_chars = 1'b1;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    emit   = 1'b0;
    result = '0;
    if (end_of_input) begin
      emit             = state.row_has_bytes;
      result.field_end = 1'b1;
      result.row_end   = 1'b1;
    end else begin
      case (state.parse_mode)
        csvp_pkg::MODE_QUOTED: begin
          if (!is_quote) begin
            emit              = 1'b1;
            result.out_byte   = data_byte;
            result.byte_valid = 1'b1;
          end
        end
        csvp_pkg::MODE_QUOTE_SEEN: begin
          if (is_quote) begin
            emit              = 1'b1;
            result.out_byte   = data_byte;
            result.byte_valid = 1'b1;
          end else if (is_delim) begin
            emit             = 1'b1;
            result.field_end = 1'b1;
          end else if (is_lf) begin
            emit             = 1'b1;
            result.field_end = 1'b1;
            result.row_end   = 1'b1;
          end else if (!is_cr) begin
            emit              = 1'b1;
            result.out_byte   = data_byte;
            result.byte_valid = 1'b1;
          end
        end
        default: begin
          if (is_quote && !state.field_has_chars) begin
            emit = 1'b0;
          end else if (is_delim) begin
            emit             = 1'b1;
            result.field_end = 1'b1;
          end else if (is_lf) begin
            emit             = 1'b1;
            result.field_end = 1'b1;
            result.row_end   = 1'b1;
          end else if (!is_cr) begin
            emit              = 1'b1;
            result.out_byte   = data_byte;
            result.byte_valid = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csvp_out_stage.sv -----
`default_nettype none
module csvp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire csvp_pkg::result_t result,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output csvp_pkg::result_t      out_result
);

  // register frees up in the same cycle its beat is taken
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_result <= result;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csv_byte_parser.sv -----
// an accepted beat is held in the input register, decoded, then registered in the out stage
// throughput: one byte per cycle, held only by back pressure on the out port
// bytes that produce nothing (opening quote, dropped cr) still pass through the input register
// reset: synchronous, clears both stages, parser state, delimiter to comma, quote to double quote
`default_nettype none
module csv_byte_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [csvp_pkg::CHAR_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [csvp_pkg::CHAR_W-1:0] data_byte,
  input  wire logic                        end_of_input,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [csvp_pkg::CHAR_W-1:0]      out_byte,
  output logic                             byte_valid,
  output logic                             field_end,
  output logic                             row_end
);

  csvp_pkg::cfg_t         cfg;
  csvp_pkg::parse_state_t state;
  csvp_pkg::parse_state_t state_next;
  csvp_pkg::result_t      result;
  csvp_pkg::result_t      out_result;

  logic                        in_held;
  logic [csvp_pkg::CHAR_W-1:0] held_byte;
  logic                        held_end;
  logic                        emit;
  logic                        can_load;
  logic                        advance;

  csvp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (csvp_pkg::reg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csvp_decode u_decode (
    .cfg          (cfg),
    .state        (state),
    .data_byte    (held_byte),
    .end_of_input (held_end),
    .state_next   (state_next),
    .emit         (emit),
    .result       (result)
  );

  csvp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (in_held && emit),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  // a held beat with no result never waits on the out port
  assign advance  = in_held && (!emit || can_load);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= data_byte;
      held_end  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csvp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign out_byte   = out_result.out_byte;
  assign byte_valid = out_result.byte_valid;
  assign field_end  = out_result.field_end;
  assign row_end    = out_result.row_end;

endmodule
`default_nettype wire

// ----- test/tb_csv_byte_parser.sv -----
module tb_csv_byte_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import csvp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BEATS = 125;

  typedef struct packed {
    logic [CHAR_W-1:0] b;
    logic              eoi;
  } stream_item_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [0:0]        cfg_index;
  logic [CHAR_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [CHAR_W-1:0] data_byte;
  logic              end_of_input;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_byte;
  logic              byte_valid;
  logic              field_end;
  logic              row_end;

  csv_byte_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .field_end    (field_end),
    .row_end      (row_end)
  );

  always #6 clk = ~clk;

  // splitter state as the block should hold it
  mode_t             split_mode;
  logic              field_open;
  logic              row_open;
  logic [CHAR_W-1:0] delim_cfg;
  logic [CHAR_W-1:0] quote_cfg;

  stream_item_t stream_q[$];
  result_t      expected_tokens[$];

  logic idle_on;
  logic in_took;
  int   hold_gap;
  int   stall_left;
  int   quiet_cycles;
  int   errors;
  int   n_bytes, n_eoi, n_chars, n_fields, n_rows, n_settings;

  // returns 1 when the beat yields a token
  function automatic bit split_byte(input logic [CHAR_W-1:0] c, input logic eoi,
                                    output result_t tok);
    bit emit;
    emit = 1'b0;
    tok  = '0;
    if (eoi) begin
      emit          = row_open;
      tok.field_end = row_open;
      tok.row_end   = row_open;
      split_mode    = MODE_NORMAL;
      field_open    = 1'b0;
      row_open      = 1'b0;
    end else begin
      row_open = 1'b1;
      case (split_mode)
        MODE_QUOTED: begin
          if (c == quote_cfg) begin
            split_mode = MODE_QUOTE_SEEN;
          end else begin
            emit = 1'b1; tok.byte_valid = 1'b1; tok.out_byte = c;
          end
        end
        MODE_QUOTE_SEEN: begin
          if (c == quote_cfg) begin
            split_mode = MODE_QUOTED;
            emit = 1'b1; tok.byte_valid = 1'b1; tok.out_byte = c;
          end else if (c == delim_cfg) begin
            split_mode = MODE_NORMAL;
            emit = 1'b1; tok.field_end = 1'b1;
          end else if (c == CH_LF) begin
            emit = 1'b1; tok.field_end = 1'b1; tok.row_end = 1'b1;
          end else if (c != CH_CR) begin
            // stray byte after the closing quote stays in the field
            split_mode = MODE_NORMAL;
            emit = 1'b1; tok.byte_valid = 1'b1; tok.out_byte = c;
          end
        end
        default: begin
          split_mode = MODE_NORMAL;
          if (c == quote_cfg && !field_open) begin
            split_mode = MODE_QUOTED;
          end else if (c == delim_cfg) begin
            emit = 1'b1; tok.field_end = 1'b1;
          end else if (c == CH_LF) begin
            emit = 1'b1; tok.field_end = 1'b1; tok.row_end = 1'b1;
          end else if (c != CH_CR) begin
            emit = 1'b1; tok.byte_valid = 1'b1; tok.out_byte = c;
          end
        end
      endcase
      if (tok.byte_valid) field_open = 1'b1;
      if (tok.field_end) field_open = 1'b0;
      if (tok.row_end) begin
        split_mode = MODE_NORMAL;
        row_open   = 1'b0;
      end
    end
    return emit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_beat(input logic [CHAR_W-1:0] b, input logic eoi);
    stream_item_t it;
    it.b   = b;
    it.eoi = eoi;
    stream_q.insert(stream_q.size(), it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
  endfunction

  // biased toward the bytes the splitter reacts to
  function automatic logic [CHAR_W-1:0] any_char();
    case ($urandom_range(0, 9))
      0:       return delim_cfg;
      1:       return quote_cfg;
      2:       return CH_LF;
      3:       return CH_CR;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_row();
    int nf, len;
    logic [CHAR_W-1:0] c;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 1) == 1) begin
        add_beat(quote_cfg, 1'b0);
        for (int k = 0; k < len; k++) begin
          c = any_char();
          add_beat(c, 1'b0);
          if (c == quote_cfg) add_beat(c, 1'b0);
        end
        add_beat(quote_cfg, 1'b0);
      end else begin
        for (int k = 0; k < len; k++) add_beat(CHAR_W'($urandom_range(0, 255)), 1'b0);
      end
      if (f < nf - 1) add_beat(delim_cfg, 1'b0);
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        add_beat(CH_CR, 1'b0);
        add_beat(CH_LF, 1'b0);
      end
      2:       add_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
      default: add_beat(CH_LF, 1'b0);
    endcase
  endfunction

  task automatic settle();
    while (stream_q.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    // bytes with no token may still be inside the block
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CHAR_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_DELIMITER) delim_cfg = val;
    else quote_cfg = val;
  endtask

  function automatic void note_error(input string what, input result_t want,
                                     input result_t got);
    if (errors < 10)
      $display("%0t %s: want byte=%02h bv=%b fe=%b re=%b, got byte=%02h bv=%b fe=%b re=%b",
               $realtime, what, want.out_byte, want.byte_valid, want.field_end,
               want.row_end, got.out_byte, got.byte_valid, got.field_end, got.row_end);
    errors++;
  endfunction

  // input driver
  always @(negedge clk) begin
    stream_item_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold until taken
    end else if (hold_gap > 0) begin
      in_valid <= 1'b0;
      hold_gap <= hold_gap - 1;
    end else if (stream_q.size() > 0) begin
      beat = stream_q.pop_front();
      in_valid     <= 1'b1;
      data_byte    <= beat.b;
      end_of_input <= beat.eoi;
      hold_gap     <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = '{out_byte, byte_valid, field_end, row_end};
        if (expected_tokens.size() == 0) begin
          note_error("token with none expected", '0, got);
        end else begin
          want = expected_tokens.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
              got.field_end !== want.field_end || got.row_end !== want.row_end)
            note_error("token mismatch", want, got);
        end
        n_chars  += got.byte_valid;
        n_fields += got.field_end;
        n_rows   += got.row_end;
      end
      if (in_valid && in_ready) begin
        if (end_of_input) n_eoi++;
        else n_bytes++;
        if (split_byte(data_byte, end_of_input, want))
          expected_tokens.insert(expected_tokens.size(), want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_csv_byte_parser: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CHAR_W-1:0] delims [NUM_PHASES];
    logic [CHAR_W-1:0] quotes [NUM_PHASES];
    delims = '{8'd44, 8'h00, 8'hFF, 8'd34, CH_LF, 8'd44, 8'd59, 8'd44};
    quotes = '{8'd34, 8'hFF, 8'h00, 8'd34, 8'd34, CH_CR, 8'd39, 8'd34};
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_DELIMITER;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    end_of_input = 1'b0;
    out_ready    = 1'b0;
    in_took      = 1'b0;
    hold_gap     = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    errors       = 0;
    idle_on      = 1'b1;
    n_bytes = 0; n_eoi = 0; n_chars = 0; n_fields = 0; n_rows = 0; n_settings = 1;
    split_mode = MODE_NORMAL;
    field_open = 1'b0;
    row_open   = 1'b0;
    delim_cfg  = DELIMITER_RESET;
    quote_cfg  = QUOTE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset delimiter and quote
    add_text("a\"b,");
    add_text("\"x\"\"y\"z,");
    add_text("\"\",");
    add_text("\"\r,\n\"\r\n");
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hA5, 1'b1);
    add_beat(8'h5A, 1'b1);
    add_text("\"q");
    add_beat(8'h00, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph == 6) begin
        delims[ph] = CHAR_W'($urandom_range(0, 255));
        quotes[ph] = CHAR_W'($urandom_range(0, 255));
      end
      write_reg(REG_DELIMITER, delims[ph]);
      write_reg(REG_QUOTE, quotes[ph]);
      n_settings++;
      idle_on = (ph != 2) && ($urandom_range(0, 3) != 0 || ph == 0);
      while (stream_q.size() < PHASE_BEATS) begin
        case ($urandom_range(0, 19))
          0, 1, 2: repeat ($urandom_range(1, 8)) add_beat(any_char(), 1'b0);
          3:       add_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
          default: add_row();
        endcase
      end
    end

    settle();
    repeat (5) @(posedge clk);
    errors += expected_tokens.size();
    $display("sent %0d bytes and %0d end-of-input beats under %0d delimiter/quote settings",
             n_bytes, n_eoi, n_settings);
    $display("checked %0d content bytes, %0d field ends, %0d row ends; %0d errors",
             n_chars, n_fields, n_rows, errors);
    if (errors == 0) begin
      $display("tb_csv_byte_parser: PASS");
    end else begin
      $display("tb_csv_byte_parser: FAIL");
    end
    $finish;
  end

endmodule
